// ===== rtl/thmbar_pkg.sv =====
package thmbar_pkg;

  // Strip geometry
  localparam int STRIP_PIXELS = 64;
  localparam int PIX_W        = 6;

  // Transaction field widths
  localparam int TEMP_W = 12;
  localparam int LUX_W  = 17;
  localparam int CHAN_W = 8;

  // Operation codes
  localparam logic [1:0] OP_MOD_TEMP = 2'd0;
  localparam logic [1:0] OP_MOD_ERR  = 2'd1;
  localparam logic [1:0] OP_TAG_TEMP = 2'd2;
  localparam logic [1:0] OP_LUX      = 2'd3;

  // Bar scale: -20 C .. +50 C, in sixteenths of a degree
  localparam int TEMP_OFFSET = 320;
  localparam int SPAN        = 1120;

  // Width of STRIP_PIXELS * (t16 + 320), signed
  localparam int NUM_W = $clog2(STRIP_PIXELS * 2368) + 1;
  // Width of the running threshold (i+1) * SPAN
  localparam int ACC_W = $clog2(STRIP_PIXELS * SPAN + SPAN + 1);
  // Width of brightness * STRIP_PIXELS
  localparam int BN_W  = $clog2(255 * STRIP_PIXELS + 1);

  // Brightness from illuminance
  localparam int LUX_RESET    = 5000;
  localparam int LUX_SAT      = 1000;
  localparam int WHITE_LUX    = 50;
  localparam int BRIGHT_FLOOR = 8;
  // floor(x / 992) = floor(floor(x / 32) / 31); 1/31 as 8457 / 2^18
  localparam int Y_W          = 13;
  localparam int RECIP_31     = 8457;
  localparam int RECIP_SHIFT  = 18;
  localparam int RECIP_W      = Y_W + 14;

  // Gradient segments
  localparam logic [1:0] SEG_BLUE_GREEN  = 2'd0;
  localparam logic [1:0] SEG_GREEN_YELLOW = 2'd1;
  localparam logic [1:0] SEG_YELLOW_RED  = 2'd2;

endpackage

// ===== rtl/thermometer_heat_map_bar_graph_unit.sv =====
// A redraw enters the draw state when the transaction is taken; the draw state loads
// pixel 0 into the output register, then one pixel per cycle while the output is not stalled.
// A drawing temperature holds the input stalled until all 64 pixels are issued; a lux
// update passes through the multiply and reciprocal states; others finish in idle.
// Reset (synchronous, rst high): illuminance 5000 lux, brightness 255, main module
// not live, output register empty, sequencer idle.
module thermometer_heat_map_bar_graph_unit
  import thmbar_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               operation,
  input  logic signed [TEMP_W-1:0] temperature,
  input  logic [LUX_W-1:0]         lux,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PIX_W-1:0]         pixel,
  output logic [CHAN_W-1:0]        red,
  output logic [CHAN_W-1:0]        green,
  output logic [CHAN_W-1:0]        blue,
  output logic                     white,
  output logic                     last
);

  // Sequencer states
  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_DRAW     = 2'd1;
  localparam logic [1:0] ST_BR_MUL   = 2'd2;
  localparam logic [1:0] ST_BR_RECIP = 2'd3;

  localparam logic signed [NUM_W-1:0] OFFSET_S = NUM_W'(TEMP_OFFSET);
  localparam logic signed [NUM_W-1:0] SCALE_S  = NUM_W'(STRIP_PIXELS);

  logic [1:0]              state;
  logic                    module_live;
  logic [LUX_W-1:0]        ambient_lux;
  logic [CHAN_W-1:0]       bright;
  logic                    dim;
  logic [Y_W-1:0]          y_scaled;

  // Redraw loop registers
  logic signed [NUM_W-1:0] num;    // STRIP_PIXELS * (t16 + 320)
  logic [ACC_W-1:0]        acc;    // (idx + 1) * SPAN
  logic [PIX_W-1:0]        idx;    // current pixel
  logic [PIX_W-1:0]        rem;    // 3*idx mod STRIP_PIXELS
  logic [1:0]              seg;    // 3*idx div STRIP_PIXELS
  logic [BN_W-1:0]         part;   // bright * rem

  logic                    in_accept;
  logic                    out_free;
  logic signed [NUM_W-1:0] t_ext;
  logic signed [NUM_W-1:0] num_calc;
  logic signed [NUM_W-1:0] acc_s;
  logic                    lit;
  logic                    is_last;
  logic [9:0]              bright3;
  logic [BN_W-1:0]         bright_n;
  logic [PIX_W:0]          rem_sum;
  logic                    wrap;
  logic [PIX_W-1:0]        rem_next;
  logic [BN_W:0]           part_sum;
  logic [BN_W-1:0]         part_next;
  logic [CHAN_W-1:0]       lo_v;
  logic [CHAN_W-1:0]       hi_v;
  logic [CHAN_W-1:0]       red_next;
  logic [CHAN_W-1:0]       green_next;
  logic [CHAN_W-1:0]       blue_next;
  logic [17:0]             lux_prod;
  logic [RECIP_W-1:0]      recip_prod;
  logic [9:0]              bsum;
  logic [CHAN_W-1:0]       bright_calc;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Bar length numerator; a pixel is lit when (idx+1)*SPAN <= num
  assign t_ext    = NUM_W'(temperature);
  assign num_calc = (t_ext + OFFSET_S) * SCALE_S;
  assign acc_s    = signed'(NUM_W'(acc));
  assign lit      = (acc_s <= num);
  assign is_last  = (idx == PIX_W'(STRIP_PIXELS - 1));

  // Step the gradient position by three per pixel, wrapping once per segment
  assign bright3  = {2'b00, bright} + {1'b0, bright, 1'b0};
  assign bright_n = BN_W'(bright * BN_W'(STRIP_PIXELS));
  assign rem_sum  = {1'b0, rem} + (PIX_W + 1)'(3);
  assign wrap     = (rem_sum >= (PIX_W + 1)'(STRIP_PIXELS));
  assign rem_next = wrap ? PIX_W'(rem_sum - (PIX_W + 1)'(STRIP_PIXELS)) : rem_sum[PIX_W-1:0];
  assign part_sum  = {1'b0, part} + (BN_W + 1)'(bright3);
  assign part_next = wrap ? BN_W'(part_sum - {1'b0, bright_n}) : part_sum[BN_W-1:0];

  // Rising and falling shares of the current segment
  assign lo_v = CHAN_W'(part / STRIP_PIXELS);
  assign hi_v = CHAN_W'((bright_n - part) / STRIP_PIXELS);

  always_comb begin
    red_next   = '0;
    green_next = '0;
    blue_next  = '0;
    case (seg)
      SEG_BLUE_GREEN: begin
        green_next = lo_v;
        blue_next  = hi_v;
      end
      SEG_GREEN_YELLOW: begin
        red_next   = lo_v;
        green_next = bright;
      end
      SEG_YELLOW_RED: begin
        red_next   = bright;
        green_next = hi_v;
      end
      default: begin
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
      end
    endcase
  end

  // Brightness: floor(lux*255/992) + 8, saturated; multiply then reciprocal state, one product each
  assign lux_prod    = 18'(ambient_lux[9:0]) * 18'(255);
  assign recip_prod  = RECIP_W'(y_scaled) * RECIP_W'(RECIP_31);
  assign bsum        = {1'b0, recip_prod[RECIP_W-1:RECIP_SHIFT]} + 10'(BRIGHT_FLOOR);
  assign bright_calc = (ambient_lux >= LUX_W'(LUX_SAT)) ? 8'hFF :
                       (bsum > 10'd255) ? 8'hFF : bsum[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      module_live <= 1'b0;
      ambient_lux <= LUX_W'(LUX_RESET);
      bright      <= 8'hFF;
      dim         <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // Drop the result once taken; while drawing, the next pixel refills it instead
      if (out_valid && !out_stall && state != ST_DRAW) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            case (operation)
              OP_MOD_TEMP, OP_TAG_TEMP: begin
                if (operation == OP_MOD_TEMP) begin
                  module_live <= 1'b1;
                end
                if (operation == OP_MOD_TEMP || !module_live) begin
                  num   <= num_calc;
                  acc   <= ACC_W'(SPAN);
                  idx   <= '0;
                  rem   <= '0;
                  seg   <= SEG_BLUE_GREEN;
                  part  <= '0;
                  state <= ST_DRAW;
                end
              end
              OP_MOD_ERR: begin
                module_live <= 1'b0;
              end
              OP_LUX: begin
                ambient_lux <= lux;
                state       <= ST_BR_MUL;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_DRAW: begin
          // Advance one pixel whenever the output register has room
          if (out_free) begin
            out_valid <= 1'b1;
            pixel     <= idx;
            red       <= lit ? red_next   : '0;
            green     <= lit ? green_next : '0;
            blue      <= lit ? blue_next  : '0;
            white     <= lit ? 1'b0 : dim;
            last      <= is_last;
            idx       <= PIX_W'(idx + PIX_W'(1));
            acc       <= ACC_W'(acc + ACC_W'(SPAN));
            rem       <= rem_next;
            seg       <= seg + 2'(wrap);
            part      <= part_next;
            if (is_last) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_BR_MUL: begin
          y_scaled <= lux_prod[17:5];
          state    <= ST_BR_RECIP;
        end
        ST_BR_RECIP: begin
          bright <= bright_calc;
          dim    <= (ambient_lux < LUX_W'(WHITE_LUX));
          state  <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/thmbar_checker.sv =====
module thmbar_checker
  import thmbar_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [1:0]               operation,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [PIX_W-1:0]         pixel,
  input logic [CHAN_W-1:0]        red,
  input logic [CHAN_W-1:0]        green,
  input logic [CHAN_W-1:0]        blue,
  input logic                     white,
  input logic                     last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel) && $stable(red) &&
      $stable(green) && $stable(blue) && $stable(white) && $stable(last))
    else $error("stalled result changed");

  // Within a redraw the next pixel follows without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("gap inside a redraw");

  // A module temperature always starts a redraw
  a_draw_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && operation == OP_MOD_TEMP |=> in_stall)
    else $error("module temperature did not start a redraw");

  // White only on unlit pixels
  a_white_dark: assert property (@(posedge clk) disable iff (rst)
    out_valid && white |-> red == '0 && green == '0 && blue == '0)
    else $error("white on a lit pixel");

endmodule

bind thermometer_heat_map_bar_graph_unit thmbar_checker u_thmbar_checker (.*);
